/* sv/bsc_pkg.sv */
// Shared types, constants and drive tables for the sensorless commutation core.
`timescale 1ns / 1ps

package bsc_pkg;

   localparam int RING_DEPTH_DEF = 8;
   localparam int CREDIT_MAX_DEF = 100;

   localparam int TIME_W   = 16;
   localparam int LAG_W    = 10;
   localparam int CREDIT_W = 7;
   localparam int STEP_W   = 3;
   localparam int ALU_W    = 17;
   localparam int CSR_AW   = 3;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   localparam logic [TIME_W-1:0] MIN_PT_RST   = 16'd82;
   localparam logic [TIME_W-1:0] MAX_PT_RST   = 16'd8200;
   localparam logic [LAG_W-1:0]  LAG_RST      = 10'd40;
   localparam logic [TIME_W-1:0] BLANK_RST    = 16'd80;
   localparam logic [TIME_W-1:0] START_PT_RST = 16'd2976;

   localparam int CREDIT_INC  = 5;
   localparam int CREDIT_FAIL = 10;

   typedef enum logic [CSR_AW-1:0] {
      CSR_MIN_PT   = 3'd0,
      CSR_MAX_PT   = 3'd1,
      CSR_LAG      = 3'd2,
      CSR_BLANK    = 3'd3,
      CSR_START_PT = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      REQ_CROSS  = 2'd0,
      REQ_EXPIRY = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_ARM    = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      BLANK_OPEN  = 2'd0,
      BLANK_DELAY = 2'd1,
      BLANK_WAIT  = 2'd2
   } blank_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PT,
      ST_FILL,
      ST_WALK,
      ST_DIV,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_CHK_MIN,
      ST_CHK_MAX,
      ST_LAG,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic acc_clr;
      logic acc_en;
   } ring_ctl_type;

   function automatic logic [2:0] high_side_f(input logic [STEP_W-1:0] s);
      logic [2:0] r;
      unique case (s)
         3'd0, 3'd1: r = 3'b001;
         3'd2, 3'd3: r = 3'b010;
         3'd4, 3'd5: r = 3'b100;
         default:    r = 3'b000;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] low_side_f(input logic [STEP_W-1:0] s);
      logic [2:0] r;
      unique case (s)
         3'd0, 3'd5: r = 3'b010;
         3'd1, 3'd2: r = 3'b100;
         3'd3, 3'd4: r = 3'b001;
         default:    r = 3'b000;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] sense_f(input logic [STEP_W-1:0] s);
      logic [1:0] r;
      unique case (s)
         3'd0, 3'd3: r = 2'd2;
         3'd1, 3'd4: r = 2'd1;
         default:    r = 2'd0;
      endcase
      return r;
   endfunction

   // Six-step advance; the two unused codes fall back into the sequence.
   function automatic logic [STEP_W-1:0] next_step_f(input logic [STEP_W-1:0] s,
                                                    input logic fwd);
      logic [STEP_W-1:0] r;
      if (fwd) begin
         r = (s >= 3'd5) ? 3'd0 : s + 3'd1;
      end else begin
         r = s - 3'd1;
         if (r >= 3'd6) begin
            r = 3'd5;
         end
      end
      return r;
   endfunction

endpackage

/* sv/bldc_sensorless_commutation_core.sv */
// Top level of the sensorless six-step commutation core: sequencer, shared unit, registers.
`timescale 1ns / 1ps

// One item at a time; req_tready is high only while the sequencer is idle. A zero crossing
// that opens a new interval goes from acceptance to result through the clamp, the ring walk
// (one ring read a cycle), four plausibility checks and the lag subtraction, then the result
// state; a single 17-bit subtract/compare unit is shared by the clamp, the four plausibility
// checks and the lag subtraction. Depths that are not a power of two add a state after the
// walk in which the ring sum is divided by a reciprocal multiply. An arm item writes one ring
// entry a cycle; every other item goes straight to the result state. The next item is taken
// in the cycle after the result is issued. The result waits in an output register, so the next
// item can be accepted while it is still unread. No clearing pass after reset: unwritten ring entries read as zero.
module bldc_sensorless_commutation_core #(
   parameter int RING_DEPTH = bsc_pkg::RING_DEPTH_DEF,
   parameter int CREDIT_MAX = bsc_pkg::CREDIT_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // config write port
   input  logic                              csr_we,
   input  logic [bsc_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [bsc_pkg::TIME_W-1:0]        csr_wdata,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // timer_count[15:0], timer_overflow[16], forward[17], running[18], zero fill
   input  logic [bsc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type[1:0]
   input  logic [1:0]                        req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // step_now[2:0], high_side[5:3], low_side[8:6], sense_phase[10:9], edge_rising[11],
   // delay_load[27:12], delay_start[28], average_time[44:29], phase_ok[45],
   // credit_level[52:46], stall_res[53], zero fill
   output logic [bsc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int POS_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SUM_W     = bsc_pkg::TIME_W + POS_W;
   localparam int CNT_W     = $clog2(SUM_W + 1);
   localparam bit RING_POW2 = (RING_DEPTH & (RING_DEPTH - 1)) == 0;
   localparam int PROD_W    = 2 * SUM_W + 1;
   // exact for every sum below 2**SUM_W
   localparam int RECIP     = (1 << (SUM_W + POS_W)) / RING_DEPTH + 1;
   localparam int TW        = bsc_pkg::TIME_W;
   localparam int AW        = bsc_pkg::ALU_W;
   localparam int CW        = bsc_pkg::CREDIT_W;

   // config registers
   logic [TW-1:0]               min_pt_ff, max_pt_ff, blank_ff, start_pt_ff;
   logic [bsc_pkg::LAG_W-1:0]   lag_ff;

   // control state
   bsc_pkg::state_type          state_ff, state_in;
   bsc_pkg::blank_type          blank_ph_ff, blank_ph_in;
   logic [bsc_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [CW-1:0]               credit_ff, credit_in;
   logic [POS_W-1:0]            pos_ff, pos_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // working and payload registers
   logic [TW-1:0]               tcount_ff, tcount_in;
   logic                        ovf_ff, ovf_in;
   logic                        fwd_ff, fwd_in;
   logic [TW-1:0]               quo_ff, quo_in;
   logic                        ok_ff, ok_in;
   logic                        above_min_ff, above_min_in;
   logic [TW-1:0]               dload_ff, dload_in;
   logic                        dstart_ff, dstart_in;
   logic [TW-1:0]               avg_out_ff, avg_out_in;
   logic                        ok_out_ff, ok_out_in;
   logic                        stall_ff, stall_in;
   logic [bsc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared subtract/compare unit
   logic [AW-1:0]               alu_a, alu_b;
   logic [AW:0]                 alu_diff;
   logic                        alu_ge;

   bsc_pkg::ring_ctl_type       ring_ctl;
   logic [POS_W-1:0]            ring_wr_addr, ring_rd_addr;
   logic [TW-1:0]               ring_wr_data;
   logic [SUM_W-1:0]            ring_sum;
   logic [TW-1:0]               ring_min, ring_max;

   logic [TW-1:0]               avg_w;
   logic [TW-1:0]               half_count;
   logic [PROD_W-1:0]           div_prod;
   logic [CW:0]                 credit_up;
   logic                        req_fire;

   bsc_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_addr (ring_rd_addr),
      .sum     (ring_sum),
      .min_val (ring_min),
      .max_val (ring_max)
   );

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = ~alu_diff[AW];

   assign avg_w      = RING_POW2 ? ring_sum[POS_W +: TW] : quo_ff;
   assign half_count = tcount_ff >> 1;
   assign div_prod   = PROD_W'(ring_sum) * PROD_W'(RECIP);
   assign credit_up  = {1'b0, credit_ff} + (CW + 1)'(bsc_pkg::CREDIT_INC);

   assign req_tready = (state_ff == bsc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      blank_ph_in  = blank_ph_ff;
      step_in      = step_ff;
      credit_in    = credit_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      tcount_in    = tcount_ff;
      ovf_in       = ovf_ff;
      fwd_in       = fwd_ff;
      quo_in       = quo_ff;
      ok_in        = ok_ff;
      above_min_in = above_min_ff;
      dload_in     = dload_ff;
      dstart_in    = dstart_ff;
      avg_out_in   = avg_out_ff;
      ok_out_in    = ok_out_ff;
      stall_in     = stall_ff;
      rsp_data_in  = rsp_data_ff;
      alu_a        = '0;
      alu_b        = '0;
      ring_ctl     = '0;
      ring_wr_addr = pos_ff;
      ring_wr_data = max_pt_ff;
      ring_rd_addr = cnt_ff[POS_W-1:0];

      unique case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (req_fire) begin
               tcount_in  = req_tdata[TW-1:0];
               ovf_in     = req_tdata[16];
               fwd_in     = req_tdata[17];
               dload_in   = '0;
               dstart_in  = 1'b0;
               avg_out_in = '0;
               ok_out_in  = 1'b0;
               stall_in   = 1'b0;
               cnt_in     = '0;
               state_in   = bsc_pkg::ST_DONE;
               unique case (bsc_pkg::req_kind_type'(req_tuser))
                  bsc_pkg::REQ_CROSS: begin
                     if (blank_ph_ff == bsc_pkg::BLANK_OPEN) begin
                        state_in = bsc_pkg::ST_PT;
                     end
                  end
                  bsc_pkg::REQ_EXPIRY: begin
                     if (blank_ph_ff == bsc_pkg::BLANK_DELAY) begin
                        blank_ph_in = bsc_pkg::BLANK_WAIT;
                        if (req_tdata[18]) begin
                           step_in = bsc_pkg::next_step_f(step_ff, req_tdata[17]);
                        end
                        dload_in  = blank_ff;
                        dstart_in = 1'b1;
                     end else if (blank_ph_ff == bsc_pkg::BLANK_WAIT) begin
                        blank_ph_in = bsc_pkg::BLANK_OPEN;
                     end
                  end
                  bsc_pkg::REQ_TICK: begin
                     if (req_tdata[18]) begin
                        credit_in = (credit_ff > CW'(1)) ? credit_ff - CW'(1) : '0;
                        stall_in  = (credit_ff <= CW'(1));
                     end
                  end
                  bsc_pkg::REQ_ARM: begin
                     blank_ph_in = bsc_pkg::BLANK_OPEN;
                     credit_in   = CW'(CREDIT_MAX);
                     state_in    = bsc_pkg::ST_FILL;
                  end
                  default: ;
               endcase
            end
         end

         // clamp the halved count and store it
         bsc_pkg::ST_PT: begin
            alu_a          = AW'(half_count);
            alu_b          = AW'(max_pt_ff);
            ring_ctl.wr_en = 1'b1;
            ring_wr_data   = (ovf_ff || alu_ge) ? max_pt_ff : half_count;
            pos_in         = (pos_ff == POS_W'(RING_DEPTH - 1)) ? '0 : pos_ff + POS_W'(1);
            cnt_in         = '0;
            state_in       = bsc_pkg::ST_WALK;
         end

         bsc_pkg::ST_FILL: begin
            ring_ctl.wr_en = 1'b1;
            ring_wr_addr   = cnt_ff[POS_W-1:0];
            ring_wr_data   = start_pt_ff;
            cnt_in         = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RING_DEPTH - 1)) begin
               state_in = bsc_pkg::ST_DONE;
            end
         end

         // read one entry a cycle, accumulate the one read before
         bsc_pkg::ST_WALK: begin
            ring_ctl.rd_en   = (cnt_ff < CNT_W'(RING_DEPTH));
            ring_ctl.acc_clr = (cnt_ff == '0);
            ring_ctl.acc_en  = (cnt_ff != '0);
            cnt_in           = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RING_DEPTH)) begin
               cnt_in   = '0;
               ok_in    = 1'b1;
               state_in = RING_POW2 ? bsc_pkg::ST_CHK_LO : bsc_pkg::ST_DIV;
            end
         end

         // average by reciprocal multiply for depths that are not a power of two
         bsc_pkg::ST_DIV: begin
            quo_in   = div_prod[SUM_W + POS_W +: TW];
            state_in = bsc_pkg::ST_CHK_LO;
         end

         bsc_pkg::ST_CHK_LO: begin
            alu_a    = {ring_min, 1'b0};
            alu_b    = AW'(avg_w);
            ok_in    = ok_ff && alu_ge;
            state_in = bsc_pkg::ST_CHK_HI;
         end

         bsc_pkg::ST_CHK_HI: begin
            alu_a    = AW'(avg_w);
            alu_b    = AW'(ring_max >> 1);
            ok_in    = ok_ff && alu_ge;
            state_in = bsc_pkg::ST_CHK_MIN;
         end

         bsc_pkg::ST_CHK_MIN: begin
            alu_a        = AW'(avg_w);
            alu_b        = AW'(min_pt_ff);
            ok_in        = ok_ff && alu_ge;
            above_min_in = alu_ge;
            state_in     = bsc_pkg::ST_CHK_MAX;
         end

         bsc_pkg::ST_CHK_MAX: begin
            alu_a    = AW'(max_pt_ff);
            alu_b    = AW'(avg_w);
            ok_in    = ok_ff && alu_ge;
            state_in = bsc_pkg::ST_LAG;
         end

         // lag-compensated delay, saturating at zero
         bsc_pkg::ST_LAG: begin
            alu_a      = AW'(above_min_ff ? avg_w : min_pt_ff);
            alu_b      = AW'(lag_ff);
            dload_in   = alu_ge ? alu_diff[TW-1:0] : '0;
            dstart_in  = 1'b1;
            avg_out_in = avg_w;
            ok_out_in  = ok_ff;
            if (ok_ff) begin
               credit_in = (credit_up > (CW + 1)'(CREDIT_MAX)) ? CW'(CREDIT_MAX)
                                                               : credit_up[CW-1:0];
            end else begin
               credit_in = (credit_ff > CW'(bsc_pkg::CREDIT_FAIL))
                           ? credit_ff - CW'(bsc_pkg::CREDIT_FAIL) : '0;
            end
            blank_ph_in = bsc_pkg::BLANK_DELAY;
            state_in    = bsc_pkg::ST_DONE;
         end

         bsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, stall_ff, credit_ff, ok_out_ff, avg_out_ff,
                               dstart_ff, dload_ff, (step_ff[0] == fwd_ff),
                               bsc_pkg::sense_f(step_ff), bsc_pkg::low_side_f(step_ff),
                               bsc_pkg::high_side_f(step_ff), step_ff};
               state_in     = bsc_pkg::ST_IDLE;
            end
         end

         default: state_in = bsc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsc_pkg::ST_IDLE;
         blank_ph_ff  <= bsc_pkg::BLANK_OPEN;
         step_ff      <= '0;
         credit_ff    <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blank_ph_ff  <= blank_ph_in;
         step_ff      <= step_in;
         credit_ff    <= credit_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tcount_ff    <= tcount_in;
      ovf_ff       <= ovf_in;
      fwd_ff       <= fwd_in;
      quo_ff       <= quo_in;
      ok_ff        <= ok_in;
      above_min_ff <= above_min_in;
      dload_ff     <= dload_in;
      dstart_ff    <= dstart_in;
      avg_out_ff   <= avg_out_in;
      ok_out_ff    <= ok_out_in;
      stall_ff     <= stall_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // config writes; indices past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pt_ff   <= bsc_pkg::MIN_PT_RST;
         max_pt_ff   <= bsc_pkg::MAX_PT_RST;
         lag_ff      <= bsc_pkg::LAG_RST;
         blank_ff    <= bsc_pkg::BLANK_RST;
         start_pt_ff <= bsc_pkg::START_PT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            bsc_pkg::CSR_MIN_PT:   min_pt_ff   <= csr_wdata;
            bsc_pkg::CSR_MAX_PT:   max_pt_ff   <= csr_wdata;
            bsc_pkg::CSR_LAG:      lag_ff      <= csr_wdata[bsc_pkg::LAG_W-1:0];
            bsc_pkg::CSR_BLANK:    blank_ff    <= csr_wdata;
            bsc_pkg::CSR_START_PT: start_pt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

/* sv/bsc_ring.sv */
// Interval ring store with registered read and the sum, minimum and maximum walk.
`timescale 1ns / 1ps

module bsc_ring #(
   parameter int RING_DEPTH = bsc_pkg::RING_DEPTH_DEF,
   localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
   localparam int SUM_W = bsc_pkg::TIME_W + POS_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bsc_pkg::ring_ctl_type        ctl,
   input  logic [POS_W-1:0]             wr_addr,
   input  logic [bsc_pkg::TIME_W-1:0]   wr_data,
   input  logic [POS_W-1:0]             rd_addr,
   output logic [SUM_W-1:0]             sum,
   output logic [bsc_pkg::TIME_W-1:0]   min_val,
   output logic [bsc_pkg::TIME_W-1:0]   max_val
);

   logic [bsc_pkg::TIME_W-1:0] mem [RING_DEPTH];
   logic [RING_DEPTH-1:0]      valid_ff;
   logic [bsc_pkg::TIME_W-1:0] rd_q_ff;
   logic                       rd_v_ff;
   logic [bsc_pkg::TIME_W-1:0] rd_val;
   logic [SUM_W-1:0]           sum_ff;
   logic [bsc_pkg::TIME_W-1:0] min_ff;
   logic [bsc_pkg::TIME_W-1:0] max_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= mem[rd_addr];
         rd_v_ff <= valid_ff[rd_addr];
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_val = rd_v_ff ? rd_q_ff : '0;

   always_ff @(posedge clock) begin
      if (ctl.acc_clr) begin
         sum_ff <= '0;
         min_ff <= '1;
         max_ff <= '0;
      end else if (ctl.acc_en) begin
         sum_ff <= sum_ff + SUM_W'(rd_val);
         if (rd_val < min_ff) begin
            min_ff <= rd_val;
         end
         if (rd_val > max_ff) begin
            max_ff <= rd_val;
         end
      end
   end

   assign sum     = sum_ff;
   assign min_val = min_ff;
   assign max_val = max_ff;

endmodule

/* dv/bldc_sensorless_commutation_core_tb.sv */
// Self-checking testbench for the sensorless six-step commutation core.
`timescale 1ns / 1ps

module bldc_sensorless_commutation_core_tb;

   localparam int RING_N       = bsc_pkg::RING_DEPTH_DEF;
   localparam int QUIET_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 20;

   // drive maps indexed by step, step 0 in the lowest slice
   localparam logic [23:0] HI_MAP    = {3'd0, 3'd0, 3'd4, 3'd4, 3'd2, 3'd2, 3'd1, 3'd1};
   localparam logic [23:0] LO_MAP    = {3'd0, 3'd0, 3'd2, 3'd1, 3'd1, 3'd4, 3'd4, 3'd2};
   localparam logic [15:0] SENSE_MAP = {2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

   typedef struct {
      bsc_pkg::req_kind_type kind;
      logic [15:0]           count;
      logic                  ovf;
      logic                  fwd;
      logic                  run;
   } motor_event_type;

   // same layout as rsp_tdata, lowest field last
   typedef struct packed {
      logic [1:0]  zero_fill;
      logic        stall_res;
      logic [6:0]  credit_level;
      logic        phase_ok;
      logic [15:0] average_time;
      logic        delay_start;
      logic [15:0] delay_load;
      logic        edge_rising;
      logic [1:0]  sense_phase;
      logic [2:0]  low_side;
      logic [2:0]  high_side;
      logic [2:0]  step_now;
   } rsp_fields_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           csr_we     = 1'b0;
   logic [bsc_pkg::CSR_AW-1:0]     csr_addr   = bsc_pkg::CSR_MIN_PT;
   logic [bsc_pkg::TIME_W-1:0]     csr_wdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bsc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]                     req_tuser  = bsc_pkg::REQ_CROSS;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bsc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   bldc_sensorless_commutation_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // commutation model state
   int                 cfg_min   = int'(bsc_pkg::MIN_PT_RST);
   int                 cfg_max   = int'(bsc_pkg::MAX_PT_RST);
   int                 cfg_lag   = int'(bsc_pkg::LAG_RST);
   int                 cfg_blank = int'(bsc_pkg::BLANK_RST);
   int                 cfg_start = int'(bsc_pkg::START_PT_RST);
   logic [15:0]        ring_model [RING_N];
   logic [2:0]         ring_idx  = '0;
   bsc_pkg::blank_type blank_st  = bsc_pkg::BLANK_OPEN;
   logic [2:0]         step_st   = '0;
   int                 credit_st = 0;

   motor_event_type event_queue [$];
   rsp_fields_type  due_results [$];
   motor_event_type cur_item;
   int              send_gap     = 0;
   int              hold_gap     = 0;
   int              burst_odds   = 0;
   int              errors       = 0;
   int              items_sent   = 0;
   int              results_seen = 0;
   int              ok_seen      = 0;
   int              stall_seen   = 0;
   int              settings_run = 1;
   int              quiet        = 0;

   function automatic rsp_fields_type commutate_event(input motor_event_type ev);
      rsp_fields_type r;
      int             pt, sum, lo_v, hi_v, avg, d;
      bit             ok;
      r = '0;
      unique case (ev.kind)
         bsc_pkg::REQ_CROSS: begin
            if (blank_st == bsc_pkg::BLANK_OPEN) begin
               pt = ev.ovf ? cfg_max : int'(ev.count >> 1);
               if (pt >= cfg_max) begin
                  pt = cfg_max;
               end
               ring_model[ring_idx] = 16'(pt);
               ring_idx = ring_idx + 3'd1;
               sum  = 0;
               lo_v = 65535;
               hi_v = 0;
               for (int k = 0; k < RING_N; k++) begin
                  sum = sum + int'(ring_model[k]);
                  if (int'(ring_model[k]) < lo_v) lo_v = int'(ring_model[k]);
                  if (int'(ring_model[k]) > hi_v) hi_v = int'(ring_model[k]);
               end
               avg = sum / RING_N;
               ok  = !(avg > 2 * lo_v) && !(avg < hi_v / 2) &&
                     !(avg < cfg_min) && !(avg > cfg_max);
               if (ok) begin
                  credit_st = credit_st + bsc_pkg::CREDIT_INC;
                  if (credit_st > bsc_pkg::CREDIT_MAX_DEF) credit_st = bsc_pkg::CREDIT_MAX_DEF;
               end else begin
                  credit_st = (credit_st > bsc_pkg::CREDIT_FAIL)
                              ? credit_st - bsc_pkg::CREDIT_FAIL : 0;
               end
               // below the plausible floor the floor itself sets the delay
               d = (avg >= cfg_min) ? avg - cfg_lag : cfg_min - cfg_lag;
               if (d < 0) d = 0;
               r.delay_load   = 16'(d);
               r.delay_start  = 1'b1;
               r.average_time = 16'(avg);
               r.phase_ok     = ok;
               blank_st       = bsc_pkg::BLANK_DELAY;
            end
         end
         bsc_pkg::REQ_EXPIRY: begin
            if (blank_st == bsc_pkg::BLANK_DELAY) begin
               blank_st = bsc_pkg::BLANK_WAIT;
               if (ev.run) begin
                  if (ev.fwd) begin
                     step_st = (step_st >= 3'd5) ? 3'd0 : step_st + 3'd1;
                  end else begin
                     step_st = step_st - 3'd1;
                     if (step_st >= 3'd6) step_st = 3'd5;
                  end
               end
               r.delay_load  = 16'(cfg_blank);
               r.delay_start = 1'b1;
            end else if (blank_st == bsc_pkg::BLANK_WAIT) begin
               blank_st = bsc_pkg::BLANK_OPEN;
            end
         end
         bsc_pkg::REQ_TICK: begin
            if (ev.run) begin
               credit_st = (credit_st > 1) ? credit_st - 1 : 0;
               r.stall_res = (credit_st == 0);
            end
         end
         bsc_pkg::REQ_ARM: begin
            for (int k = 0; k < RING_N; k++) begin
               ring_model[k] = 16'(cfg_start);
            end
            blank_st  = bsc_pkg::BLANK_OPEN;
            credit_st = bsc_pkg::CREDIT_MAX_DEF;
         end
      endcase
      r.step_now     = step_st;
      r.high_side    = HI_MAP[step_st * 3 +: 3];
      r.low_side     = LO_MAP[step_st * 3 +: 3];
      r.sense_phase  = SENSE_MAP[step_st * 2 +: 2];
      r.edge_rising  = (step_st[0] == ev.fwd);
      r.credit_level = 7'(credit_st);
      return r;
   endfunction

   // sender: one item in flight, random gaps while the slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            due_results.push_back(commutate_event(cur_item));
            items_sent++;
         end
         if (send_gap == 0 && burst_odds != 0 && $urandom_range(0, 99) < burst_odds) begin
            send_gap = $urandom_range(1, 16);
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (event_queue.size() != 0) begin
            cur_item = event_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {5'd0, cur_item.run, cur_item.fwd, cur_item.ovf, cur_item.count};
            req_tuser  <= cur_item.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string what, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (want_v !== got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      end
   endtask

   // receiver: compare each item against the oldest prediction
   always @(posedge clock) begin : receive
      rsp_fields_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = due_results.pop_front();
               results_seen++;
               ok_seen    += int'(want.phase_ok);
               stall_seen += int'(want.stall_res);
               check_field("step_now", 16'(want.step_now), 16'(got.step_now));
               check_field("high_side", 16'(want.high_side), 16'(got.high_side));
               check_field("low_side", 16'(want.low_side), 16'(got.low_side));
               check_field("sense_phase", 16'(want.sense_phase), 16'(got.sense_phase));
               check_field("edge_rising", 16'(want.edge_rising), 16'(got.edge_rising));
               check_field("delay_load", want.delay_load, got.delay_load);
               check_field("delay_start", 16'(want.delay_start), 16'(got.delay_start));
               check_field("average_time", want.average_time, got.average_time);
               check_field("phase_ok", 16'(want.phase_ok), 16'(got.phase_ok));
               check_field("credit_level", 16'(want.credit_level), 16'(got.credit_level));
               check_field("stall_res", 16'(want.stall_res), 16'(got.stall_res));
            end
         end
         if (hold_gap == 0 && burst_odds != 0 && $urandom_range(0, 99) < burst_odds) begin
            hold_gap = $urandom_range(1, 16);
         end
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push(input bsc_pkg::req_kind_type kind, input logic [15:0] count,
                       input logic ovf, input logic fwd, input logic run);
      motor_event_type ev;
      ev.kind  = kind;
      ev.count = count;
      ev.ovf   = ovf;
      ev.fwd   = fwd;
      ev.run   = run;
      event_queue.push_back(ev);
   endtask

   // block idle: nothing queued, in flight or awaited
   task automatic settle();
      do begin
         @(negedge clock);
      end while (event_queue.size() != 0 || req_tvalid || due_results.size() != 0 ||
                 !req_tready);
   endtask

   task automatic apply_settings(input int mn, input int mx, input int lag,
                                 input int blk, input int st);
      bsc_pkg::csr_idx_type idx  [5];
      int                   vals [5];
      idx  = '{bsc_pkg::CSR_MIN_PT, bsc_pkg::CSR_MAX_PT, bsc_pkg::CSR_LAG,
               bsc_pkg::CSR_BLANK, bsc_pkg::CSR_START_PT};
      vals = '{mn, mx, lag, blk, st};
      for (int k = 0; k < 5; k++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= idx[k];
         csr_wdata <= 16'(vals[k]);
      end
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_min   = mn;
      cfg_max   = mx;
      cfg_lag   = lag;
      cfg_blank = blk;
      cfg_start = st;
      settings_run++;
      @(negedge clock);
   endtask

   // mostly crossing/expiry/expiry cycles around a drifting interval, plus ticks, re-arms and noise
   task automatic make_run(input int n_eff);
      int done, target, span, cnt, pick;
      bit dir;
      done   = 0;
      target = cfg_start;
      dir    = 1'($urandom_range(0, 1));
      push(bsc_pkg::REQ_ARM, 16'($urandom), 1'($urandom_range(0, 1)), dir, 1'b1);
      while (done < n_eff) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            span = target / 8 + 1;
            cnt  = 2 * target + int'($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, 65535);
            if (cnt < 0) cnt = 0;
            if (cnt > 65535) cnt = 65535;
            push(bsc_pkg::REQ_CROSS, 16'(cnt), $urandom_range(0, 29) == 0, dir, 1'b1);
            push(bsc_pkg::REQ_EXPIRY, 16'($urandom), 1'($urandom_range(0, 1)), dir,
                 $urandom_range(0, 19) != 0);
            push(bsc_pkg::REQ_EXPIRY, 16'($urandom), 1'($urandom_range(0, 1)), dir, 1'b1);
            done += 3;
            span   = target / 16 + 1;
            target = target + int'($urandom_range(0, 2 * span)) - span;
            if (target < 0) target = 0;
            if (target > 32767) target = 32767;
            if ($urandom_range(0, 39) == 0) dir = !dir;
         end else if (pick < 84) begin
            push(bsc_pkg::REQ_TICK, 16'($urandom), 1'($urandom_range(0, 1)), dir,
                 $urandom_range(0, 9) != 0);
            done++;
         end else if (pick < 86) begin
            push(bsc_pkg::REQ_ARM, 16'($urandom), 1'($urandom_range(0, 1)), dir, 1'b1);
            target = cfg_start;
            done++;
         end else begin
            push(bsc_pkg::req_kind_type'($urandom_range(0, 3)), 16'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
            done++;
         end
      end
   endtask

   initial begin
      int mn, mx;
      for (int k = 0; k < RING_N; k++) begin
         ring_model[k] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, directed walk through the special cases
      burst_odds = 5;
      push(bsc_pkg::REQ_CROSS, 16'd1000, 1'b0, 1'b1, 1'b1);    // empty ring, credit floor
      push(bsc_pkg::REQ_CROSS, 16'd1000, 1'b0, 1'b1, 1'b1);    // blanked
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b1, 1'b1);
      push(bsc_pkg::REQ_CROSS, 16'd2000, 1'b0, 1'b1, 1'b1);    // blanked, second half
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b1, 1'b1);
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b1, 1'b1);      // detection open: no-op
      push(bsc_pkg::REQ_TICK, 16'd0, 1'b0, 1'b1, 1'b0);        // stopped: no-op
      push(bsc_pkg::REQ_TICK, 16'd0, 1'b0, 1'b1, 1'b1);        // stall at zero credit
      push(bsc_pkg::REQ_ARM, 16'd0, 1'b0, 1'b1, 1'b1);
      push(bsc_pkg::REQ_CROSS, 16'd5952, 1'b0, 1'b1, 1'b1);    // plausible, credit ceiling
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b1, 1'b0);      // stopped: step kept
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b1, 1'b0);
      push(bsc_pkg::REQ_CROSS, 16'hFFFF, 1'b0, 1'b1, 1'b1);    // long interval clamp
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b0, 1'b1);
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b0, 1'b1);
      push(bsc_pkg::REQ_CROSS, 16'h0000, 1'b1, 1'b0, 1'b1);    // timer overflow
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b0, 1'b1);      // backward wrap to 5
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b0, 1'b1);
      push(bsc_pkg::REQ_CROSS, 16'd0, 1'b0, 1'b0, 1'b1);       // below the plausible floor
      push(bsc_pkg::REQ_EXPIRY, 16'hFFFF, 1'b1, 1'b1, 1'b1);   // forward wrap to 0
      push(bsc_pkg::REQ_EXPIRY, 16'd0, 1'b0, 1'b1, 1'b1);
      push(bsc_pkg::REQ_TICK, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      push(bsc_pkg::REQ_ARM, 16'hFFFF, 1'b1, 1'b0, 1'b0);
      make_run(225);
      settle();

      // lag at its 10-bit maximum, zero blanking
      apply_settings(0, 65535, 1023, 0, 0);
      burst_odds = 20;
      make_run(225);
      settle();

      // nothing plausible: credit drains, ticks stall
      apply_settings(65535, 0, 0, 65535, 65535);
      burst_odds = 0;
      make_run(225);
      settle();

      mn = $urandom_range(0, 400);
      mx = $urandom_range(2000, 40000);
      apply_settings(mn, mx, $urandom_range(0, 1023), $urandom_range(0, 65535),
                     $urandom_range(mn, mx));
      burst_odds = 8;
      make_run(225);
      settle();

      mn = $urandom_range(0, 100);
      mx = $urandom_range(300, 3000);
      apply_settings(mn, mx, $urandom_range(0, 1023), $urandom_range(0, 65535),
                     $urandom_range(100, 2000));
      burst_odds = 35;
      make_run(225);
      settle();

      // back to reset values, flat out
      apply_settings(int'(bsc_pkg::MIN_PT_RST), int'(bsc_pkg::MAX_PT_RST),
                     int'(bsc_pkg::LAG_RST), int'(bsc_pkg::BLANK_RST),
                     int'(bsc_pkg::START_PT_RST));
      burst_odds = 0;
      make_run(225);
      settle();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (due_results.size() != 0) begin
         errors++;
         $display("%0t: %0d predicted items never arrived", $time, due_results.size());
      end
      $display("Sent %0d items across %0d register settings, checked %0d results",
               items_sent, settings_run, results_seen);
      $display("Plausible crossings %0d, stall flags %0d, mismatches %0d",
               ok_seen, stall_seen, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
